### design/bitmap_to_display_pages_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap to display pages core
// Short forms for clocked implication checks with asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_TO_DISPLAY_PAGES_CORE_MACROS_SVH
`define BITMAP_TO_DISPLAY_PAGES_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BTDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BTDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/btdp_pkg.sv
// ----------------------------------------------------------------------------
// btdp_pkg
// Types, geometry constants and address helpers for the display page core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btdp_pkg;

	// Display geometry
	localparam int COLUMNS    = 96;
	localparam int ROWS       = 16;
	localparam int PAGES      = (ROWS + 7) / 8;
	localparam int STORE_SIZE = PAGES * COLUMNS;

	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int IDX_W = $clog2(STORE_SIZE);

	// Queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int THR_W   = 7;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 7'd40;
	localparam logic [0:0]       REG_THRESHOLD   = 1'b0;

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic        command;
		logic [31:0] pixel;
	} item_t;

	typedef struct packed {
		logic [7:0] page_byte;
		logic       last;
	} result_t;

	// One classified request for the back end
	typedef struct packed {
		logic             cmd;
		logic [IDX_W-1:0] addr;
		logic [7:0]       mask;
		logic             lit;
		logic             last;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Store index of a load: flip the row, then page = row / 8
	function automatic logic [IDX_W-1:0] load_index(
		input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col
	);
		logic [ROW_W-1:0] disp_row;
		disp_row = ROW_W'(ROWS - 1) - row;
		return IDX_W'(int'(disp_row >> 3) * COLUMNS + int'(col));
	endfunction

	// Bit mask of a load inside its page byte
	function automatic logic [7:0] load_mask(input logic [ROW_W-1:0] row);
		logic [ROW_W-1:0] disp_row;
		disp_row = ROW_W'(ROWS - 1) - row;
		return 8'd1 << disp_row[2:0];
	endfunction

endpackage

`default_nettype wire

### design/bitmap_to_display_pages_core.sv
// A read request's byte passes the queue entry, the store read and the result register.
// The back end takes a new request only after it has finished the last, set by the
// read-modify-write on the single-port page store; a 2-entry queue absorbs bursts.
// Reset: pointers clear, threshold returns to 40 and the per-entry written
// flags clear at once, so the store reads as zero with no clearing pass.
// ----------------------------------------------------------------------------
// bitmap_to_display_pages_core
// Packs thresholded bitmap pixels into display page bytes and streams them out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_to_display_pages_core_macros.svh"

module bitmap_to_display_pages_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [btdp_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [btdp_pkg::PDATA_W-1:0]   pwdata,
	output logic      [btdp_pkg::PDATA_W-1:0]   prdata,
	output logic                                pready,
	// request channel
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire btdp_pkg::item_t                item,
	// result channel
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output btdp_pkg::result_t                   result
);

	logic [btdp_pkg::THR_W-1:0] threshold_q;
	logic                       push;
	logic                       pop;
	btdp_pkg::op_t              push_op;
	btdp_pkg::op_t              head;
	btdp_pkg::qstat_t           qstat;
	logic                       thr_sel;

	assign pready  = 1'b1;
	assign thr_sel = (paddr[2:2] == btdp_pkg::REG_THRESHOLD);

	// Return the threshold register on reads
	assign prdata = thr_sel ? btdp_pkg::PDATA_W'(threshold_q) : '0;

	// Write the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= btdp_pkg::THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready && thr_sel) begin
			threshold_q <= pwdata[btdp_pkg::THR_W-1:0];
		end
	end

	btdp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.threshold  (threshold_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.qstat      (qstat),
		.push       (push),
		.push_op    (push_op)
	);

	btdp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	btdp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Check queue use and back-end sequencing
	`BTDP_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !qstat.full, "push into full queue")
	`BTDP_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !qstat.empty, "pop from empty queue")
	`BTDP_ASSERT_NEXT(a_pop_spacing, clk, arst_n, pop, !pop, "back end popped twice in a row")
	`BTDP_ASSERT_IMP(a_result_source, clk, arst_n, $rose(result_valid), $past(pop, 2), "result without pop")

endmodule

`default_nettype wire

### design/btdp_front.sv
// ----------------------------------------------------------------------------
// btdp_front
// Accepts requests, thresholds pixels and turns pointers into store addresses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btdp_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [btdp_pkg::THR_W-1:0]    threshold,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire btdp_pkg::item_t               item,
	input  wire btdp_pkg::qstat_t              qstat,
	output logic                               push,
	output btdp_pkg::op_t                      push_op
);

	logic [btdp_pkg::COL_W-1:0] col_q;
	logic [btdp_pkg::ROW_W-1:0] row_q;
	logic [btdp_pkg::IDX_W-1:0] rd_idx_q;
	logic                       lit;
	logic                       rd_last;

	assign item_ready = !qstat.full;
	assign push       = item_valid && item_ready;

	// Light the pixel when any of the upper three colour bytes, halved, exceeds the threshold
	assign lit = (item.pixel[15:9]  > threshold) ||
	             (item.pixel[23:17] > threshold) ||
	             (item.pixel[31:25] > threshold);

	assign rd_last = (rd_idx_q == btdp_pkg::IDX_W'(btdp_pkg::STORE_SIZE - 1));

	// Classify the request
	always_comb begin
		push_op.cmd  = item.command;
		push_op.lit  = lit;
		push_op.last = rd_last;
		if (item.command == btdp_pkg::CMD_READ) begin
			push_op.addr = rd_idx_q;
			push_op.mask = 8'h00;
		end else begin
			push_op.addr = btdp_pkg::load_index(row_q, col_q);
			push_op.mask = btdp_pkg::load_mask(row_q);
		end
	end

	// Advance load and read pointers, wrapping at their ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			rd_idx_q <= '0;
		end else if (push) begin
			if (item.command == btdp_pkg::CMD_READ) begin
				if (rd_last) begin
					rd_idx_q <= '0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end else begin
				if (col_q == btdp_pkg::COL_W'(btdp_pkg::COLUMNS - 1)) begin
					col_q <= '0;
					if (row_q == btdp_pkg::ROW_W'(btdp_pkg::ROWS - 1)) begin
						row_q <= '0;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

### design/btdp_queue.sv
// ----------------------------------------------------------------------------
// btdp_queue
// Short FIFO of classified requests between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btdp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire btdp_pkg::op_t    push_op,
	input  wire logic             pop,
	output btdp_pkg::op_t         head,
	output btdp_pkg::qstat_t      qstat
);

	btdp_pkg::op_t                 entries_q [btdp_pkg::QDEPTH];
	logic [btdp_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [btdp_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [btdp_pkg::QCNT_W-1:0]   count_q;

	assign head        = entries_q[rd_ptr_q];
	assign qstat.full  = (count_q == btdp_pkg::QCNT_W'(btdp_pkg::QDEPTH));
	assign qstat.empty = (count_q == '0);

	// Store pushed requests
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == btdp_pkg::QPTR_W'(btdp_pkg::QDEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (rd_ptr_q == btdp_pkg::QPTR_W'(btdp_pkg::QDEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### design/btdp_back.sv
// ----------------------------------------------------------------------------
// btdp_back
// Executes requests on the page store: read-modify-write loads and reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btdp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire btdp_pkg::qstat_t  qstat,
	input  wire btdp_pkg::op_t     head,
	output logic                   pop,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output btdp_pkg::result_t      result
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t                          state_q;
	btdp_pkg::op_t                   op_q;
	logic [7:0]                      store_q [btdp_pkg::STORE_SIZE];
	logic [btdp_pkg::STORE_SIZE-1:0] written_q;
	logic [7:0]                      rdata_s1;
	logic                            hit_s1;
	logic [7:0]                      cur_byte;
	logic [7:0]                      new_byte;
	logic                            slot_free;
	logic                            store_we;
	btdp_pkg::result_t               result_q;
	logic                            result_valid_q;

	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign slot_free    = !result_valid_q || result_ready;

	// Pop a request when idle; a read also needs a free result slot
	always_comb begin
		pop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop = !qstat.empty && ((head.cmd == btdp_pkg::CMD_LOAD) || slot_free);
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Unwritten entries read as zero; merge the load bit
	assign cur_byte = hit_s1 ? rdata_s1 : 8'h00;
	assign new_byte = op_q.lit ? (cur_byte | op_q.mask) : (cur_byte & ~op_q.mask);
	assign store_we = (state_q == ST_EXEC) && (op_q.cmd == btdp_pkg::CMD_LOAD);

	// Store memory: registered read, single write port
	always_ff @(posedge clk) begin
		if (pop) begin
			rdata_s1 <= store_q[head.addr];
		end
		if (store_we) begin
			store_q[op_q.addr] <= new_byte;
		end
	end

	// Capture the popped request and, for a read, the result byte
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q   <= head;
			hit_s1 <= written_q[head.addr];
		end
		if ((state_q == ST_EXEC) && (op_q.cmd == btdp_pkg::CMD_READ)) begin
			result_q.page_byte <= cur_byte;
			result_q.last      <= op_q.last;
		end
	end

	// Sequence, written flags and result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			written_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
					if (result_valid_q && result_ready) begin
						result_valid_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					if (op_q.cmd == btdp_pkg::CMD_READ) begin
						result_valid_q <= 1'b1;
					end else begin
						written_q[op_q.addr] <= 1'b1;
						if (result_valid_q && result_ready) begin
							result_valid_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
